@@ hw/rtl/h2fp_pkg.sv @@
// Shared types and constants for the HTTP/2 frame parser.
package h2fp_pkg;

   localparam logic [7:0] TYPE_DATA    = 8'd0;
   localparam logic [7:0] TYPE_HEADERS = 8'd1;
   localparam logic [7:0] TYPE_PRIO    = 8'd2;
   localparam logic [7:0] TYPE_RST     = 8'd3;
   localparam logic [7:0] TYPE_SET     = 8'd4;
   localparam logic [7:0] TYPE_PING    = 8'd6;
   localparam logic [7:0] TYPE_GOAWAY  = 8'd7;
   localparam logic [7:0] TYPE_WINUPD  = 8'd8;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_PROTO = 2'd1;
   localparam logic [1:0] ST_SIZE  = 2'd2;

   localparam logic [15:0] SET_ENABLE_PUSH = 16'd2;
   localparam logic [15:0] SET_INIT_WINDOW = 16'd4;
   localparam logic [15:0] SET_MAX_FRAME   = 16'd5;

   localparam int FL_PADDED_BIT = 3;
   localparam int FL_PRIO_BIT   = 5;

   localparam logic [8:0] DEFAULT_WEIGHT = 9'd16;

   typedef struct packed {
      logic        kind;
      logic [7:0]  frame_type;
      logic [7:0]  frame_flags;
      logic [30:0] stream_number;
      logic [1:0]  status;
      logic [31:0] value_high;
      logic [31:0] value_low;
      logic [30:0] dependency;
      logic        exclusive;
      logic [8:0]  weight;
      logic [3:0]  body_offset;
      logic [23:0] body_length;
   } result_type;

   // Snapshot of a finished frame (or settings entry) handed to the back part.
   typedef struct packed {
      logic        is_entry;    // settings entry result
      logic        is_oversize; // oversize header summary
      logic        has_entry;   // entry result, followed by the summary when has_summary is set
      logic        has_summary;
      logic [1:0]  entry_status;
      logic [7:0]  frame_type;
      logic [7:0]  frame_flags;
      logic [30:0] stream;
      logic [23:0] length;
      logic [7:0]  pad;
      logic [63:0] gather;
      logic [39:0] prio;
      logic [1:0]  pending;
   } event_type;

endpackage

@@ hw/rtl/h2fp_stream_if.sv @@
// Valid/ready channel interface carrying one payload of Width bits.
interface h2fp_stream_if #(parameter int Width = 8) (input logic clock);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/h2fp_front.sv @@
// Front part: byte parsing, field gathering and event generation.
module h2fp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic [23:0]        size_limit,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         in_byte,
   output logic               ev_valid,
   input  logic               ev_ready,
   output h2fp_pkg::event_type ev_data
);
   import h2fp_pkg::*;

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_STOP    = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [23:0] count_ff, count_in;
   logic [23:0] len_ff, len_in;
   logic [7:0]  type_ff, type_in, flags_ff, flags_in, pad_ff, pad_in;
   logic [30:0] stream_ff, stream_in;
   logic [63:0] gather_ff, gather_in;
   logic [39:0] prio_ff, prio_in;
   logic [1:0]  pend_ff, pend_in;
   logic [2:0]  mod6_ff, mod6_in;
   logic        fire;
   logic        padded, prio_flag, takes_prio;
   logic [23:0] pstart, count_inc;
   logic [15:0] set_id;
   logic [31:0] set_val;
   logic [1:0]  set_st;
   event_type   ev;

   assign fire     = in_valid && in_ready;
   assign in_ready = ev_ready;
   assign padded    = flags_ff[FL_PADDED_BIT];
   assign prio_flag = flags_ff[FL_PRIO_BIT];
   assign count_inc = count_ff + 24'd1;

   // Classify the settings entry completed by this byte.
   always_comb begin
      logic [63:0] g;
      g = {gather_ff[55:0], in_byte};
      set_id  = g[47:32];
      set_val = g[31:0];
      set_st  = ST_OK;
      if (set_id == SET_ENABLE_PUSH && set_val > 32'd1) set_st = ST_PROTO;
      else if (set_id == SET_INIT_WINDOW && set_val[31]) set_st = ST_PROTO;
      else if (set_id == SET_MAX_FRAME && (set_val < 32'd16384 || set_val[31:24] != 8'd0))
         set_st = ST_PROTO;
   end

   // Advance parse state and build the event for this byte.
   always_comb begin
      phase_in = phase_ff; count_in = count_ff; len_in = len_ff;
      type_in = type_ff; flags_in = flags_ff; stream_in = stream_ff;
      pad_in = pad_ff; gather_in = gather_ff; prio_in = prio_ff;
      pend_in = pend_ff; mod6_in = mod6_ff;
      takes_prio = 1'b0; pstart = 24'd0;
      ev = '0;
      ev_valid = 1'b0;
      if (fire) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (count_ff < 24'd3) len_in = {len_ff[15:0], in_byte};
               else if (count_ff == 24'd3) type_in = in_byte;
               else if (count_ff == 24'd4) flags_in = in_byte;
               else stream_in = {stream_ff[22:0], in_byte};
               if (count_ff < 24'd8) begin
                  count_in = count_inc;
               end else begin
                  count_in = 24'd0; pad_in = 8'd0; gather_in = '0;
                  prio_in = '0; pend_in = ST_OK; mod6_in = 3'd0;
                  ev.frame_type = type_ff; ev.frame_flags = flags_ff;
                  ev.stream = stream_in; ev.length = len_ff;
                  if (len_ff > size_limit) begin
                     ev_valid = 1'b1; ev.is_oversize = 1'b1; ev.has_summary = 1'b1;
                     phase_in = PH_STOP;
                  end else if (len_ff == 24'd0) begin
                     ev_valid = 1'b1; ev.has_summary = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (type_ff == TYPE_SET || count_ff < 24'd8)
                  gather_in = {gather_ff[55:0], in_byte};
               if ((type_ff == TYPE_DATA || type_ff == TYPE_HEADERS) && padded &&
                   count_ff == 24'd0) pad_in = in_byte;
               if (type_ff == TYPE_HEADERS && prio_flag) begin
                  takes_prio = 1'b1; pstart = {23'd0, padded};
               end else if (type_ff == TYPE_PRIO) takes_prio = 1'b1;
               if (takes_prio && count_ff >= pstart && count_ff < pstart + 24'd5)
                  prio_in = {prio_ff[31:0], in_byte};
               mod6_in = (mod6_ff == 3'd5) ? 3'd0 : mod6_ff + 3'd1;
               ev.frame_type = type_ff; ev.frame_flags = flags_ff; ev.stream = stream_ff;
               ev.length = len_ff; ev.pad = pad_in; ev.gather = gather_in;
               ev.prio = prio_in;
               if (type_ff == TYPE_SET && mod6_ff == 3'd5) begin
                  ev_valid = 1'b1; ev.has_entry = 1'b1; ev.entry_status = set_st;
                  if (pend_ff == ST_OK) pend_in = set_st;
               end
               ev.pending = pend_in;
               count_in = count_inc;
               if (count_inc >= len_ff) begin
                  ev_valid = 1'b1; ev.has_summary = 1'b1;
                  phase_in = PH_HEADER; count_in = 24'd0;
               end
            end
            default: ;
         endcase
      end
      ev.is_entry = ev.has_entry;
      ev_data = ev;
   end

   // Hold parse state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; count_ff <= '0; len_ff <= '0; type_ff <= '0;
         flags_ff <= '0; stream_ff <= '0; pad_ff <= '0; gather_ff <= '0;
         prio_ff <= '0; pend_ff <= ST_OK; mod6_ff <= '0;
      end else begin
         phase_ff <= phase_in; count_ff <= count_in; len_ff <= len_in;
         type_ff <= type_in; flags_ff <= flags_in; stream_ff <= stream_in;
         pad_ff <= pad_in; gather_ff <= gather_in; prio_ff <= prio_in;
         pend_ff <= pend_in; mod6_ff <= mod6_in;
      end
   end
endmodule

@@ hw/rtl/h2fp_queue.sv @@
// Two-entry event queue between front and back parts.
module h2fp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_valid,
   output logic                wr_ready,
   input  h2fp_pkg::event_type wr_data,
   output logic                rd_valid,
   input  logic                rd_ready,
   output h2fp_pkg::event_type rd_data
);
   import h2fp_pkg::*;

   event_type  mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rptr_ff];
   assign push = wr_valid && wr_ready;
   assign pop  = rd_valid && rd_ready;

   // Store incoming events.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= wr_data;
   end

   // Advance pointers and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0; rptr_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop) rptr_ff <= !rptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

@@ hw/rtl/h2fp_back.sv @@
// Back part: frame validation and result emission.
module h2fp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                ev_valid,
   output logic                ev_ready,
   input  h2fp_pkg::event_type ev_data,
   output logic                out_valid,
   input  logic                out_ready,
   output h2fp_pkg::result_type out_data
);
   import h2fp_pkg::*;

   logic       entry_done_ff, entry_done_in;
   logic       valid_ff, valid_in;
   result_type res_ff, res_in;
   result_type entry_res, sum_res;
   logic       last_part, take_slot, load;

   // Build the settings entry result.
   always_comb begin
      entry_res = '0;
      entry_res.kind = 1'b0;
      entry_res.frame_type = ev_data.frame_type;
      entry_res.frame_flags = ev_data.frame_flags;
      entry_res.stream_number = ev_data.stream;
      entry_res.status = ev_data.entry_status;
      entry_res.value_high = {16'd0, ev_data.gather[47:32]};
      entry_res.value_low = ev_data.gather[31:0];
      entry_res.weight = DEFAULT_WEIGHT;
   end

   // Validate the frame and build its summary.
   always_comb begin
      logic [23:0] len, rem, padv;
      logic [3:0]  off;
      logic [30:0] s, pdep;
      logic        padded, prio, zero;
      logic [1:0]  st;
      len = ev_data.length; s = ev_data.stream;
      padv = {16'd0, ev_data.pad};
      padded = ev_data.frame_flags[FL_PADDED_BIT];
      prio = ev_data.frame_flags[FL_PRIO_BIT];
      pdep = ev_data.prio[38:8];
      zero = (s == 31'd0);
      rem = len; off = 4'd0;
      sum_res = '0;
      sum_res.kind = 1'b1;
      sum_res.frame_type = ev_data.frame_type;
      sum_res.frame_flags = ev_data.frame_flags;
      sum_res.stream_number = s;
      sum_res.weight = DEFAULT_WEIGHT;
      st = ST_OK;
      if (ev_data.is_oversize) begin
         st = ST_SIZE;
      end else begin
         case (ev_data.frame_type)
            TYPE_DATA: begin
               if (zero) st = ST_PROTO;
               else if (padded) begin
                  if (len == 24'd0 || padv > len - 24'd1) st = ST_PROTO;
                  else begin
                     sum_res.body_offset = 4'd1;
                     sum_res.body_length = len - 24'd1 - padv;
                  end
               end else sum_res.body_length = len;
            end
            TYPE_HEADERS: begin
               if (!padded) padv = 24'd0;
               if (zero) st = ST_PROTO;
               else if (padded && (len == 24'd0 || padv > len - 24'd1)) st = ST_PROTO;
               else begin
                  if (padded) begin
                     rem = len - 24'd1; off = 4'd1;
                  end
                  if (prio) begin
                     if (rem < 24'd5) st = ST_SIZE;
                     else if (rem - padv < 24'd5) st = ST_PROTO;
                     else if (pdep == s) st = ST_PROTO;
                     else begin
                        sum_res.dependency = pdep;
                        sum_res.exclusive = ev_data.prio[39];
                        sum_res.weight = {1'b0, ev_data.prio[7:0]} + 9'd1;
                        rem = rem - 24'd5; off = off + 4'd5;
                     end
                  end
                  sum_res.body_offset = off;
                  sum_res.body_length = rem - padv;
               end
            end
            TYPE_PRIO: begin
               if (zero) st = ST_PROTO;
               else if (len != 24'd5) st = ST_SIZE;
               else if (pdep == s) st = ST_PROTO;
               else begin
                  sum_res.dependency = pdep;
                  sum_res.exclusive = ev_data.prio[39];
                  sum_res.weight = {1'b0, ev_data.prio[7:0]} + 9'd1;
               end
            end
            TYPE_RST: begin
               if (zero) st = ST_PROTO;
               else if (len != 24'd4) st = ST_SIZE;
               else sum_res.value_low = ev_data.gather[31:0];
            end
            TYPE_SET: begin
               st = ev_data.pending;
               // A non-empty payload of whole entries always ends on an entry byte
               if (st == ST_OK && !ev_data.has_entry && len != 24'd0) st = ST_SIZE;
            end
            TYPE_PING: begin
               if (!zero) st = ST_PROTO;
               else if (len != 24'd8) st = ST_SIZE;
               else begin
                  sum_res.value_high = ev_data.gather[63:32];
                  sum_res.value_low = ev_data.gather[31:0];
               end
            end
            TYPE_GOAWAY: begin
               if (!zero) st = ST_PROTO;
               else if (len < 24'd8) st = ST_SIZE;
               else begin
                  sum_res.value_high = {1'b0, ev_data.gather[62:32]};
                  sum_res.value_low = ev_data.gather[31:0];
                  sum_res.body_offset = 4'd8;
                  sum_res.body_length = len - 24'd8;
               end
            end
            TYPE_WINUPD: begin
               if (len != 24'd4) st = ST_SIZE;
               else if (ev_data.gather[30:0] == 31'd0) st = ST_PROTO;
               else sum_res.value_low = {1'b0, ev_data.gather[30:0]};
            end
            default: ;
         endcase
      end
      if (st != ST_OK) begin
         sum_res.value_high = '0; sum_res.value_low = '0; sum_res.dependency = '0;
         sum_res.exclusive = 1'b0; sum_res.weight = DEFAULT_WEIGHT;
         sum_res.body_offset = '0; sum_res.body_length = '0;
      end
      sum_res.status = st;
   end

   // Drain one result per event part into the output register.
   assign take_slot = !valid_ff || out_ready;
   assign load = ev_valid && take_slot;
   assign last_part = !ev_data.has_summary || entry_done_ff || !ev_data.has_entry;
   assign ev_ready = load && last_part;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      res_in = res_ff;
      entry_done_in = entry_done_ff;
      if (load) begin
         valid_in = 1'b1;
         if (ev_data.has_entry && !entry_done_ff) begin
            res_in = entry_res;
            entry_done_in = ev_data.has_summary;
         end else begin
            res_in = sum_res;
            entry_done_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0; entry_done_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in; entry_done_ff <= entry_done_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign out_valid = valid_ff;
   assign out_data = res_ff;
endmodule

@@ hw/rtl/http2_frame_parser.sv @@
// Top level of the HTTP/2 frame parser.
//  channel | dir | payload               | handshake
//  req     | in  | data_byte (8)         | valid/ready
//  rsp     | out | result fields (12)    | valid/ready
//  csr     | in  | size_limit (24)       | write enable
// Each byte needs only counter and field updates, so one byte is taken per cycle while
// the event queue has room. A frame's summary reaches rsp via the event queue and the
// output register; a byte ending a settings entry and its frame yields two results.
// Reset is synchronous and active high; an oversize header halts until reset.
// Output stalls back up through the two-entry event queue to req_ready.
module http2_frame_parser (
   input  logic         clock,
   input  logic         reset,
   h2fp_stream_if.sink   req,
   h2fp_stream_if.source rsp,
   input  logic         csr_write_enable,
   input  logic [23:0]  csr_write_data
);
   import h2fp_pkg::*;

   logic [23:0] max_size_ff;
   logic        fe_valid, fe_ready, be_valid, be_ready;
   event_type   fe_data, be_data;
   result_type  res;

   // Hold the configured maximum frame size.
   always_ff @(posedge clock) begin
      if (reset) max_size_ff <= 24'd16384;
      else if (csr_write_enable) max_size_ff <= csr_write_data;
   end

   h2fp_front u_front (
      .clock, .reset, .size_limit(max_size_ff),
      .in_valid(req.valid), .in_ready(req.ready), .in_byte(req.data),
      .ev_valid(fe_valid), .ev_ready(fe_ready), .ev_data(fe_data)
   );

   h2fp_queue u_queue (
      .clock, .reset,
      .wr_valid(fe_valid), .wr_ready(fe_ready), .wr_data(fe_data),
      .rd_valid(be_valid), .rd_ready(be_ready), .rd_data(be_data)
   );

   h2fp_back u_back (
      .clock, .reset,
      .ev_valid(be_valid), .ev_ready(be_ready), .ev_data(be_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(res)
   );

   assign rsp.data = res;
endmodule

@@ hw/rtl/h2fp_checker.sv @@
// Port-level assertions for the HTTP/2 frame parser, with bind.
module h2fp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [8:0]  rsp_weight,
   input logic        rsp_kind,
   input logic [3:0]  rsp_offset
);
   ap_ready: assert property (@(posedge clock)
      reset |=> req_ready) else $error("req not ready after reset");
   ap_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   ap_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
   ap_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != 2'd0 |-> rsp_weight == 9'd16) else $error("bad weight");
   ap_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_offset == 4'd0) else $error("entry offset");
endmodule

bind http2_frame_parser h2fp_checker u_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.data[134:133]),
   .rsp_weight(rsp.data[36:28]), .rsp_kind(rsp.data[182]), .rsp_offset(rsp.data[27:24])
);

@@ bench/tb_http2_frame_parser.sv @@
// Self-checking testbench for the HTTP/2 frame parser with a built-in byte-level predictor.
module tb_http2_frame_parser;
   timeunit 1ns;
   timeprecision 1ps;
   import h2fp_pkg::*;

   typedef enum logic [1:0] {PARSE_HEADER, PARSE_PAYLOAD, PARSE_HALTED} parse_phase_t;

   localparam int LIMIT_CYCLES = 400000;
   localparam int TAIL_CYCLES  = 20;
   localparam int IDLE_NONE    = 0;
   localparam int IDLE_SENDER  = 1;
   localparam int IDLE_RECV    = 2;
   localparam int IDLE_BOTH    = 3;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [23:0] csr_write_data;

   h2fp_stream_if #(.Width(8)) req (clock);
   h2fp_stream_if #(.Width($bits(result_type))) rsp (clock);

   http2_frame_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req             (req.sink),
      .rsp             (rsp.source),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   // Stream bytes waiting to go out, and results still owed by the block
   logic [7:0] stream_bytes[$];
   result_type awaited_results[$];

   // Parser model state
   logic [23:0]  frame_limit;
   parse_phase_t parse_phase;
   logic [23:0]  byte_index;
   logic [23:0]  frame_length;
   logic [7:0]   frame_kind;
   logic [7:0]   frame_flag_bits;
   logic [30:0]  frame_stream;
   logic [7:0]   pad_bytes;
   logic [63:0]  gathered;
   logic [39:0]  prio_bytes;
   logic [1:0]   settings_status;

   int   idle_mode;
   int   hold_left;
   bit   req_taken;
   int   cycle_count;
   int   mismatches;
   int   bytes_accepted;
   int   entries_seen;
   int   summaries_seen;
   int   status_seen[4];

   // Clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic result_type pack_result(logic k, logic [1:0] st, logic [31:0] vh,
         logic [31:0] vl, logic [30:0] dep, logic ex, logic [8:0] wt, logic [3:0] bo,
         logic [23:0] bl);
      result_type r;
      r.kind = k;
      r.frame_type = frame_kind;
      r.frame_flags = frame_flag_bits;
      r.stream_number = frame_stream;
      r.status = st;
      r.value_high = vh;
      r.value_low = vl;
      r.dependency = dep;
      r.exclusive = ex;
      r.weight = wt;
      r.body_offset = bo;
      r.body_length = bl;
      return r;
   endfunction

   // Build the end-of-frame summary from the gathered header and payload state
   function automatic result_type frame_summary();
      int unsigned len, pad, rem, off;
      logic [1:0]  st;
      logic [31:0] vh, vl, hi, lo;
      logic [30:0] dep, pdep;
      logic        ex, padded, prio;
      logic [8:0]  wt;
      logic [3:0]  bo;
      logic [23:0] bl;
      len = frame_length;
      pad = pad_bytes;
      padded = frame_flag_bits[FL_PADDED_BIT];
      prio = frame_flag_bits[FL_PRIO_BIT];
      st = ST_OK; vh = 0; vl = 0; dep = 0; ex = 0; wt = DEFAULT_WEIGHT; bo = 0; bl = 0;
      pdep = prio_bytes[38:8];
      hi = gathered[63:32];
      lo = gathered[31:0];
      case (frame_kind)
         TYPE_DATA: begin
            if (frame_stream == 0) st = ST_PROTO;
            else if (padded) begin
               if (len < 1 || pad > len - 1) st = ST_PROTO;
               else begin
                  bo = 1;
                  bl = len - 1 - pad;
               end
            end else bl = len;
         end
         TYPE_HEADERS: begin
            rem = len;
            off = 0;
            if (frame_stream == 0) st = ST_PROTO;
            else if (padded && (len < 1 || pad > len - 1)) st = ST_PROTO;
            else begin
               if (padded) begin
                  rem = len - 1;
                  off = 1;
               end else pad = 0;
               if (prio) begin
                  if (rem < 5) st = ST_SIZE;
                  else if (rem - pad < 5) st = ST_PROTO;
                  else if (pdep == frame_stream) st = ST_PROTO;
                  else begin
                     dep = pdep;
                     ex = prio_bytes[39];
                     wt = prio_bytes[7:0] + 9'd1;
                     rem -= 5;
                     off += 5;
                  end
               end
               bo = off;
               bl = rem - pad;
            end
         end
         TYPE_PRIO: begin
            if (frame_stream == 0) st = ST_PROTO;
            else if (len != 5) st = ST_SIZE;
            else if (pdep == frame_stream) st = ST_PROTO;
            else begin
               dep = pdep;
               ex = prio_bytes[39];
               wt = prio_bytes[7:0] + 9'd1;
            end
         end
         TYPE_RST: begin
            if (frame_stream == 0) st = ST_PROTO;
            else if (len != 4) st = ST_SIZE;
            else vl = lo;
         end
         TYPE_SET: begin
            st = settings_status;
            if (st == ST_OK && (len % 6) != 0) st = ST_SIZE;
         end
         TYPE_PING: begin
            if (frame_stream != 0) st = ST_PROTO;
            else if (len != 8) st = ST_SIZE;
            else begin
               vh = hi;
               vl = lo;
            end
         end
         TYPE_GOAWAY: begin
            if (frame_stream != 0) st = ST_PROTO;
            else if (len < 8) st = ST_SIZE;
            else begin
               vh = {1'b0, hi[30:0]};
               vl = lo;
               bo = 8;
               bl = len - 8;
            end
         end
         TYPE_WINUPD: begin
            if (len != 4) st = ST_SIZE;
            else if (lo[30:0] == 0) st = ST_PROTO;
            else vl = {1'b0, lo[30:0]};
         end
         default: ;
      endcase
      if (st != ST_OK) begin
         vh = 0; vl = 0; dep = 0; ex = 0; wt = DEFAULT_WEIGHT; bo = 0; bl = 0;
      end
      return pack_result(1'b1, st, vh, vl, dep, ex, wt, bo, bl);
   endfunction

   // Advance the parser model by one accepted request byte
   task automatic parse_byte(logic [7:0] b);
      int unsigned i;
      int unsigned pstart;
      bit          takes_prio;
      logic [15:0] id;
      logic [31:0] v;
      logic [1:0]  st;
      i = byte_index;
      pstart = 0;
      takes_prio = 0;
      if (parse_phase == PARSE_HEADER) begin
         if (i < 3) frame_length = {frame_length[15:0], b};
         else if (i == 3) frame_kind = b;
         else if (i == 4) frame_flag_bits = b;
         else frame_stream = {frame_stream[22:0], b};
         if (i < 8) begin
            byte_index = i + 1;
         end else begin
            byte_index = 0;
            pad_bytes = 0;
            gathered = 0;
            prio_bytes = 0;
            settings_status = ST_OK;
            if (frame_length > frame_limit) begin
               awaited_results.push_back(pack_result(1'b1, ST_SIZE, 0, 0, 0, 0,
                  DEFAULT_WEIGHT, 0, 0));
               parse_phase = PARSE_HALTED;
            end else if (frame_length == 0) begin
               awaited_results.push_back(frame_summary());
            end else parse_phase = PARSE_PAYLOAD;
         end
      end else if (parse_phase == PARSE_PAYLOAD) begin
         if (frame_kind == TYPE_SET || i < 8) gathered = {gathered[55:0], b};
         if ((frame_kind == TYPE_DATA || frame_kind == TYPE_HEADERS)
               && frame_flag_bits[FL_PADDED_BIT] && i == 0) pad_bytes = b;
         if (frame_kind == TYPE_HEADERS && frame_flag_bits[FL_PRIO_BIT]) begin
            takes_prio = 1;
            pstart = frame_flag_bits[FL_PADDED_BIT] ? 1 : 0;
         end else if (frame_kind == TYPE_PRIO) takes_prio = 1;
         if (takes_prio && i >= pstart && i < pstart + 5) prio_bytes = {prio_bytes[31:0], b};
         if (frame_kind == TYPE_SET && ((i + 1) % 6) == 0) begin
            id = gathered[47:32];
            v = gathered[31:0];
            st = ST_OK;
            if (id == SET_ENABLE_PUSH && v > 1) st = ST_PROTO;
            else if (id == SET_INIT_WINDOW && v > 32'h7FFF_FFFF) st = ST_PROTO;
            else if (id == SET_MAX_FRAME && (v < 16384 || v > 16777215)) st = ST_PROTO;
            if (settings_status == ST_OK) settings_status = st;
            awaited_results.push_back(pack_result(1'b0, st, {16'd0, id}, v, 0, 0,
               DEFAULT_WEIGHT, 0, 0));
         end
         byte_index = i + 1;
         if (byte_index >= frame_length) begin
            awaited_results.push_back(frame_summary());
            parse_phase = PARSE_HEADER;
            byte_index = 0;
         end
      end
   endtask

   // Queue one whole frame: header then payload
   task automatic queue_frame(logic [7:0] ftype, logic [7:0] flags, logic [31:0] sid,
         logic [7:0] body[$]);
      int len;
      len = body.size();
      stream_bytes.push_back(len[23:16]);
      stream_bytes.push_back(len[15:8]);
      stream_bytes.push_back(len[7:0]);
      stream_bytes.push_back(ftype);
      stream_bytes.push_back(flags);
      for (int k = 3; k >= 0; k--) stream_bytes.push_back(sid[8*k +: 8]);
      foreach (body[k]) stream_bytes.push_back(body[k]);
   endtask

   function automatic logic [31:0] pick_setting_value();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return 2;
         3: return 32'h7FFF_FFFF;
         4: return 32'h8000_0000;
         5: return 16383;
         6: return 16384;
         7: return 16777215;
         8: return 16777216;
         default: return $urandom;
      endcase
   endfunction

   // Queue one random, mostly well-formed frame no longer than max_len
   task automatic queue_random_frame(int max_len);
      logic [7:0]  body[$];
      logic [7:0]  ftype, flags;
      logic [31:0] sid, word;
      logic [15:0] id;
      int len, sel, pstart;
      sel = $urandom_range(0, 9);
      flags = $urandom;
      sid = ($urandom_range(0, 4) == 0) ? {$urandom_range(0, 1) == 1, 31'd0} : $urandom;
      len = $urandom_range(0, 12);
      for (int k = 0; k < 40; k++) body.push_back($urandom);
      case (sel)
         0: ftype = TYPE_DATA;
         1: ftype = TYPE_HEADERS;
         2: ftype = TYPE_PRIO;
         3: ftype = TYPE_RST;
         4: ftype = TYPE_SET;
         5: ftype = TYPE_PING;
         6: ftype = TYPE_GOAWAY;
         7: ftype = TYPE_WINUPD;
         default: ftype = $urandom_range(0, 3) == 0 ? 8'd5 : $urandom_range(9, 255);
      endcase
      if ((sel == 2 || sel == 3 || sel == 5 || sel == 6) && $urandom_range(0, 3) != 0)
         sid = (sel >= 5) ? {$urandom_range(0, 1) == 1, 31'd0} : sid;
      case (sel)
         0, 1: begin
            len = $urandom_range(0, 16);
            body[0] = $urandom_range(0, len + 1);
         end
         2: len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 5;
         3, 7: len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 4;
         5: len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 8;
         6: len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 14);
         default: ;
      endcase
      // Point the priority dependency at the frame's own stream now and then
      if ((sel == 1 || sel == 2) && $urandom_range(0, 3) == 0) begin
         pstart = (sel == 1 && flags[FL_PADDED_BIT]) ? 1 : 0;
         word = {$urandom_range(0, 1) == 1, sid[30:0]};
         for (int k = 0; k < 4; k++) body[pstart + k] = word[8*(3-k) +: 8];
      end
      // Zero increment, either reserved bit value
      if (sel == 7 && $urandom_range(0, 2) == 0) begin
         body[0] = {$urandom_range(0, 1) == 1, 7'd0};
         body[1] = 0; body[2] = 0; body[3] = 0;
      end
      if (sel == 4) begin
         len = 6 * $urandom_range(0, 3);
         if ($urandom_range(0, 4) == 0) len += $urandom_range(1, 5);
         for (int e = 0; e < 4; e++) begin
            case ($urandom_range(0, 3))
               0: id = SET_ENABLE_PUSH;
               1: id = SET_INIT_WINDOW;
               2: id = SET_MAX_FRAME;
               default: id = $urandom;
            endcase
            word = pick_setting_value();
            body[6*e] = id[15:8];
            body[6*e+1] = id[7:0];
            for (int k = 0; k < 4; k++) body[6*e+2+k] = word[8*(3-k) +: 8];
         end
      end
      if (len > max_len) len = max_len;
      while (body.size() > len) void'(body.pop_back());
      queue_frame(ftype, flags, sid, body);
   endtask

   // Hold until the stream is drained and no result is owed, then let the pipe settle
   task automatic wait_drained();
      while (stream_bytes.size() != 0 || req.valid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_limit(logic [23:0] value);
      wait_drained();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      frame_limit = value;
   endtask

   // Random frames under several idle patterns until about byte_goal bytes were queued
   task automatic random_phase(int byte_goal, int max_len);
      int start;
      start = bytes_accepted + stream_bytes.size();
      while (bytes_accepted + stream_bytes.size() - start < byte_goal) begin
         idle_mode = $urandom_range(IDLE_NONE, IDLE_BOTH);
         for (int f = 0; f < 4; f++) queue_random_frame(max_len);
         while (stream_bytes.size() > 8) @(posedge clock);
      end
   endtask

   // Request driver: hold the byte until taken, else offer the next one
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (req.valid && !req_taken) begin
         req.valid <= 1'b1;
      end else if (stream_bytes.size() != 0 && !((idle_mode == IDLE_SENDER
            && $urandom_range(0, 99) < 81) || (idle_mode == IDLE_BOTH
            && $urandom_range(0, 99) < 22))) begin
         req.data <= stream_bytes.pop_front();
         req.valid <= 1'b1;
      end else begin
         req.valid <= 1'b0;
      end
   end

   // Result receiver: long hold-off when requested, else random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else if ((idle_mode == IDLE_RECV && $urandom_range(0, 99) < 81)
            || (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 22)) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // Monitor: predict on accepted bytes, check accepted results, watch the clock budget
   always @(posedge clock) begin
      result_type got, want;
      string      diff;
      req_taken <= !reset && req.valid && req.ready;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count,
               awaited_results.size());
            $display("TEST FAILED");
            $finish;
         end
         if (req.valid && req.ready) begin
            bytes_accepted <= bytes_accepted + 1;
            parse_byte(req.data);
         end
         if (rsp.valid && rsp.ready) begin
            got = rsp.data;
            if (awaited_results.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected result %p", got);
            end else begin
               want = awaited_results.pop_front();
               diff = "";
               if (got.kind !== want.kind) diff = {diff, " kind"};
               if (got.frame_type !== want.frame_type) diff = {diff, " frame_type"};
               if (got.frame_flags !== want.frame_flags) diff = {diff, " frame_flags"};
               if (got.stream_number !== want.stream_number) diff = {diff, " stream_number"};
               if (got.status !== want.status) diff = {diff, " status"};
               if (got.value_high !== want.value_high) diff = {diff, " value_high"};
               if (got.value_low !== want.value_low) diff = {diff, " value_low"};
               if (got.dependency !== want.dependency) diff = {diff, " dependency"};
               if (got.exclusive !== want.exclusive) diff = {diff, " exclusive"};
               if (got.weight !== want.weight) diff = {diff, " weight"};
               if (got.body_offset !== want.body_offset) diff = {diff, " body_offset"};
               if (got.body_length !== want.body_length) diff = {diff, " body_length"};
               if (diff != "") begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10) begin
                     $display("mismatch in%s", diff);
                     $display("  expected %p", want);
                     $display("  actual   %p", got);
                  end
               end
               if (want.kind) summaries_seen <= summaries_seen + 1;
               else entries_seen <= entries_seen + 1;
               status_seen[want.status] <= status_seen[want.status] + 1;
            end
         end
      end
   end

   // Stimulus sequence and end of run
   initial begin
      logic [7:0] body[$];
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
      idle_mode = IDLE_NONE;
      hold_left = 0;
      req_taken = 0;
      cycle_count = 0;
      mismatches = 0;
      bytes_accepted = 0;
      entries_seen = 0;
      summaries_seen = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
      frame_limit = 24'd16384;
      parse_phase = PARSE_HEADER;
      byte_index = 0;
      frame_length = 0;
      frame_kind = 0;
      frame_flag_bits = 0;
      frame_stream = 0;
      pad_bytes = 0;
      gathered = 0;
      prio_bytes = 0;
      settings_status = ST_OK;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty DATA on stream zero, then an all-ones PING
      body = {};
      queue_frame(TYPE_DATA, 8'h00, 32'h0000_0000, body);
      for (int k = 0; k < 8; k++) body.push_back(8'hFF);
      queue_frame(TYPE_PING, 8'hFF, 32'h8000_0000, body);
      wait_drained();

      // Widest limit, random frames
      write_frame_limit(24'hFF_FFFF);
      random_phase(100, 40);

      // Tight limit; stall the receiver long while bytes keep coming
      write_frame_limit(24'd40);
      @(posedge clock);
      idle_mode = IDLE_NONE;
      hold_left = 400;
      for (int f = 0; f < 12; f++) queue_random_frame(40);
      wait_drained();
      random_phase(90, 40);

      // Back to the default limit with random idle patterns
      write_frame_limit(24'd16384);
      random_phase(90, 40);

      // Zero limit: empty frames pass, the first payload-bearing header halts the block
      write_frame_limit(24'd0);
      idle_mode = IDLE_BOTH;
      body = {};
      queue_frame(TYPE_SET, 8'h01, 32'h0000_0000, body);
      queue_frame(TYPE_WINUPD, 8'h00, 32'h0000_0005, body);
      body.push_back(8'h00);
      queue_frame(TYPE_DATA, 8'h00, 32'h0000_0001, body);
      for (int k = 0; k < 20; k++) stream_bytes.push_back($urandom);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d bytes; checked %0d frame summaries and %0d settings entries",
         bytes_accepted, summaries_seen, entries_seen);
      $display("status counts ok/protocol/size: %0d/%0d/%0d", status_seen[0],
         status_seen[1], status_seen[2]);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatches,
            awaited_results.size());
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

@@ sim.f @@
hw/rtl/h2fp_pkg.sv
hw/rtl/h2fp_stream_if.sv
hw/rtl/h2fp_front.sv
hw/rtl/h2fp_queue.sv
hw/rtl/h2fp_back.sv
hw/rtl/http2_frame_parser.sv
hw/rtl/h2fp_checker.sv
bench/tb_http2_frame_parser.sv
